/* src/tpgs_pkg.sv */
// shared constants, types and the 5x7 font for the text page glyph streamer
package tpgs_pkg;

  // screen geometry
  localparam int TEXT_ROWS   = 8;
  localparam int TEXT_COLS   = 21;
  localparam int PANEL_WIDTH = 128;
  localparam int PAD_RAW     = PANEL_WIDTH - 6 * TEXT_COLS;
  localparam int PAD_BYTES   = (PAD_RAW > 0) ? PAD_RAW : 0;

  // counter widths
  localparam int ROW_W = 3;
  localparam int COL_W = 5;
  localparam int POS_W = 6;

  // positions within the byte sequence of one character
  localparam logic [POS_W-1:0] POS_CMD_FIRST = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CMD_PAGE  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CMD_LOW   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CMD_HIGH  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_DATA_OPEN = POS_W'(4);
  localparam logic [POS_W-1:0] POS_GLYPH     = POS_W'(5);
  localparam logic [POS_W-1:0] POS_SPACER    = POS_W'(10);
  localparam logic [POS_W-1:0] POS_ROW_END   = POS_W'(10 + PAD_BYTES);

  // panel command and data bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] DATA_OPEN     = 8'h40;

  // input queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // one queued input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       screen_start;
  } tpgs_item_t;

  localparam int ITEM_W = $bits(tpgs_item_t);

  // queue to sequencer handshake
  typedef struct packed {
    logic       valid;
    tpgs_item_t item;
  } tpgs_head_t;

  // font tables, bit 0 at the top
  localparam logic [7:0] DIGIT_ROM [10][5] = '{
    '{8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h42,8'h7f,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4b,8'h31},
    '{8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1e}
  };

  localparam logic [7:0] ALPHA_ROM [26][5] = '{
    '{8'h7e,8'h11,8'h11,8'h11,8'h7e}, '{8'h7f,8'h49,8'h49,8'h49,8'h36},
    '{8'h3e,8'h41,8'h41,8'h41,8'h22}, '{8'h7f,8'h41,8'h41,8'h22,8'h1c},
    '{8'h7f,8'h49,8'h49,8'h49,8'h41}, '{8'h7f,8'h09,8'h09,8'h09,8'h01},
    '{8'h3e,8'h41,8'h49,8'h49,8'h7a}, '{8'h7f,8'h08,8'h08,8'h08,8'h7f},
    '{8'h00,8'h41,8'h7f,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3f,8'h01},
    '{8'h7f,8'h08,8'h14,8'h22,8'h41}, '{8'h7f,8'h40,8'h40,8'h40,8'h40},
    '{8'h7f,8'h02,8'h0c,8'h02,8'h7f}, '{8'h7f,8'h04,8'h08,8'h10,8'h7f},
    '{8'h3e,8'h41,8'h41,8'h41,8'h3e}, '{8'h7f,8'h09,8'h09,8'h09,8'h06},
    '{8'h3e,8'h41,8'h51,8'h21,8'h5e}, '{8'h7f,8'h09,8'h19,8'h29,8'h46},
    '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7f,8'h01,8'h01},
    '{8'h3f,8'h40,8'h40,8'h40,8'h3f}, '{8'h1f,8'h20,8'h40,8'h20,8'h1f},
    '{8'h3f,8'h40,8'h38,8'h40,8'h3f}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
    '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43}
  };

  // column x (0..4) of the glyph for character c, blank for unknown codes
  function automatic logic [7:0] font_column(input logic [7:0] c, input logic [2:0] x);
    logic [7:0] col;
    logic [7:0] d_off;
    logic [7:0] a_off;
    d_off = c - 8'h30;
    a_off = c - 8'h41;
    col   = 8'h00;
    if (x <= 3'd4) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        col = DIGIT_ROM[d_off[3:0]][x];
      end else if (c >= 8'h41 && c <= 8'h5a) begin
        col = ALPHA_ROM[a_off[4:0]][x];
      end else if (c == 8'h2d) begin
        col = 8'h08;
      end else if (c == 8'h2e) begin
        col = (x == 3'd2) ? 8'h60 : 8'h00;
      end else if (c == 8'h3a) begin
        col = (x == 3'd2) ? 8'h36 : 8'h00;
      end else if (c == 8'h2f) begin
        col = 8'h20 >> x;
      end else if (c == 8'h2b) begin
        col = (x == 3'd2) ? 8'h3e : 8'h08;
      end
    end
    return col;
  endfunction

endpackage

/* src/tpgs_ram.sv */
// generic single write port ram with registered read
module tpgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tpgs_inq.sv */
// input queue: ram backed fifo with a prefetched head register
module tpgs_inq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpgs_pkg::tpgs_item_t in_item,
  output tpgs_pkg::tpgs_head_t head,
  input  logic                pop
);
  import tpgs_pkg::*;

  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QCW-1:0]  count;
  logic            rd_pending;
  logic            h_valid;
  tpgs_item_t      h_item;
  logic [ITEM_W-1:0] rdata;
  logic            push;
  logic            issue;

  // queue control
  assign in_ready = (count != QCW'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign issue    = (count != '0) && !rd_pending && (!h_valid || pop);

  tpgs_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(QDEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (in_item),
    .re    (issue),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (issue) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(issue);
    end
  end

  // head register fed from the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      h_valid    <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (rd_pending) begin
        h_valid <= 1'b1;
      end else if (pop) begin
        h_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      h_item <= tpgs_item_t'(rdata);
    end
  end

  assign head.valid = h_valid;
  assign head.item  = h_item;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue fill count beyond depth");
  a_pending_empty_head: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> !h_valid)
    else $error("ram read lands on an occupied head");
  a_pending_fills: assert property (@(posedge clk) disable iff (rst)
    rd_pending |=> h_valid)
    else $error("ram read did not fill the head");

endmodule

/* src/tpgs_seq.sv */
// byte sequencer: row and column counters, font lookup and output register
module tpgs_seq (
  input  logic                clk,
  input  logic                rst,
  input  tpgs_pkg::tpgs_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                is_command,
  output logic                end_of_transfer,
  output logic                last
);
  import tpgs_pkg::*;

  logic             busy;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] end_pos;
  logic             row_done;
  logic [7:0]       cur_char;
  logic [ROW_W-1:0] cur_page;
  logic [ROW_W-1:0] page_row;
  logic [COL_W-1:0] char_column;

  logic             advance;
  logic             finish;
  logic             load;
  logic [ROW_W-1:0] eff_page;
  logic [COL_W-1:0] eff_col;
  logic             eff_first;
  logic             eff_done;
  logic [ROW_W:0]   page_inc;
  logic [7:0]       byte_next;
  logic [2:0]       glyph_x;
  logic [POS_W-1:0] glyph_off;

  // sequencing
  assign advance = busy && (!out_valid || out_ready);
  assign finish  = advance && (pos == end_pos);
  assign load    = head.valid && (!busy || finish);
  assign pop     = load;

  // counters as seen by the arriving character
  assign eff_page  = head.item.screen_start ? '0 : page_row;
  assign eff_col   = head.item.screen_start ? '0 : char_column;
  assign eff_first = (eff_col == '0);
  assign eff_done  = ({1'b0, eff_col} + (COL_W+1)'(1)) >= (COL_W+1)'(TEXT_COLS);
  assign page_inc  = {1'b0, eff_page} + (ROW_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      page_row    <= '0;
      char_column <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        if (eff_done) begin
          char_column <= '0;
          page_row    <= (page_inc >= (ROW_W+1)'(TEXT_ROWS)) ? '0 : page_inc[ROW_W-1:0];
        end else begin
          page_row    <= eff_page;
          char_column <= eff_col + COL_W'(1);
        end
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  // per character position register
  always_ff @(posedge clk) begin
    if (load) begin
      pos      <= eff_first ? POS_CMD_FIRST : POS_GLYPH;
      end_pos  <= eff_done ? POS_ROW_END : POS_SPACER;
      row_done <= eff_done;
      cur_char <= head.item.char_code;
      cur_page <= eff_page;
    end else if (advance) begin
      pos <= pos + POS_W'(1);
    end
  end

  // byte selection
  assign glyph_off = pos - POS_GLYPH;
  assign glyph_x   = glyph_off[2:0];

  always_comb begin
    byte_next = 8'h00;
    if (pos == POS_CMD_PAGE) begin
      byte_next = CMD_PAGE_BASE + {{(8-ROW_W){1'b0}}, cur_page};
    end else if (pos == POS_CMD_HIGH) begin
      byte_next = CMD_COL_HIGH;
    end else if (pos == POS_DATA_OPEN) begin
      byte_next = DATA_OPEN;
    end else if (pos >= POS_GLYPH && pos < POS_SPACER) begin
      byte_next = font_column(cur_char, glyph_x);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte        <= byte_next;
      is_command      <= (pos < POS_DATA_OPEN);
      end_of_transfer <= (pos == POS_CMD_HIGH) || (row_done && (pos == end_pos));
      last            <= (pos == end_pos);
    end
  end

  // checks
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos <= end_pos))
    else $error("byte position ran past end of character");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    char_column < COL_W'(TEXT_COLS))
    else $error("column counter out of range");
  a_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command |-> !last)
    else $error("command byte marked as final result");

endmodule

/* src/text_page_glyph_streamer.sv */
// top level of the text page glyph streamer
// throughput: one byte per cycle while out_ready is high; a character is 6 bytes, 11 for the first cell of a row,
// plus the pad bytes on the last cell of a row, all through the single output byte path
// a four entry input queue lets transactions be accepted while bytes are still going out
// reset (synchronous, active high) empties the queue and returns to page 0, column 0
module text_page_glyph_streamer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       screen_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_command,
  output logic       end_of_transfer,
  output logic       last
);
  import tpgs_pkg::*;

  tpgs_item_t in_item;
  tpgs_head_t head;
  logic       pop;

  assign in_item.char_code    = char_code;
  assign in_item.screen_start = screen_start;

  // input queue
  tpgs_inq u_inq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  // byte sequencer
  tpgs_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .is_command      (is_command),
    .end_of_transfer (end_of_transfer),
    .last            (last)
  );

endmodule
